[rtl/gms_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and codes of the graph modularity score unit.
package gms_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int WGT_W     = 16;
    localparam int LABEL_W   = 6;
    localparam int DEG_W     = WGT_W + NODE_W + 2;
    localparam int TOT_W     = DEG_W + NODE_W - 1;
    localparam int S2_W      = 2 * TOT_W - 1;
    localparam int PROD_W    = DEG_W + TOT_W;
    localparam int DIV_W     = S2_W + 24;
    localparam int Q1_W      = 25;
    localparam int W_W       = TOT_W + 25;
    localparam int V_W       = 37;
    localparam int RES_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CNTCFG_W  = 7;
    localparam int DCNT_W    = $clog2(DIV_W + 1);

    localparam logic [1:0] OP_LOAD_EDGE = 2'd0;
    localparam logic [1:0] OP_LOAD_COMM = 2'd1;
    localparam logic [1:0] OP_COMPUTE   = 2'd2;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_RESOLUTION = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_P1_ROW, ST_P1_ROWW, ST_P1_RD, ST_P1_ACC, ST_P1_END, ST_CHK,
        ST_P2_ROW, ST_P2_ROWW, ST_P2_RD, ST_P2_ACC, ST_P2_MUL, ST_P2_ADD,
        ST_DIV1_GO, ST_DIV1_WAIT, ST_DIV2_GO, ST_DIV2_WAIT, ST_DIV3_GO, ST_DIV3_WAIT,
        ST_MUL, ST_FIN, ST_OUT
    } gms_state_t;

    typedef struct packed {
        logic                edge_we;
        logic [ADDR_W-1:0]   edge_waddr;
        logic [WGT_W-1:0]    edge_wdata;
        logic [ADDR_W-1:0]   edge_raddr;
        logic                comm_we;
        logic [NODE_W-1:0]   comm_waddr;
        logic [LABEL_W-1:0]  comm_wdata;
        logic [NODE_W-1:0]   comm_raddr;
        logic                deg_we;
        logic [NODE_W-1:0]   deg_waddr;
        logic [DEG_W-1:0]    deg_wdata;
        logic [NODE_W-1:0]   deg_raddr;
    } gms_store_ctl_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [TOT_W-1:0]   divisor;
    } gms_div_req_t;

endpackage

[rtl/graph_modularity_score_unit.sv]
`timescale 1ns / 1ps
// Graph modularity score unit: loads a weighted graph and emits its modularity.
// Load beats (edge weight or community label) leave the unit idle; ready stays high.
// A compute beat holds ready low until its result is taken into the output register: two pair
// walks over the N nodes in use, three divider passes and the finishing steps; an empty graph
// skips the second walk and the divisions.
// Synchronous reset clears sequencer and output valid, sets node_count 64, resolution 1.0.
module graph_modularity_score_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [gms_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [gms_pkg::NODE_W-1:0]         s_row_node,
    input  logic [gms_pkg::NODE_W-1:0]         s_col_node,
    input  logic [gms_pkg::WGT_W-1:0]          s_edge_weight,
    input  logic [gms_pkg::LABEL_W-1:0]        s_community,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [31:0]                 m_modularity,
    output logic                               m_empty_graph
);
    import gms_pkg::*;

    // Configuration registers.
    logic [CNTCFG_W-1:0] node_count_reg;
    logic [RES_W-1:0]    resolution_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CNTCFG_W'(MAX_NODES);
            resolution_reg <= RES_W'(4096);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data[CNTCFG_W-1:0];
                CFG_RESOLUTION: resolution_reg <= cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // Index of the last node in use: a count of zero acts as one, and counts above
    // the node capacity are clipped to it.
    logic [NODE_W-1:0] last_node;
    always_comb begin
        if (node_count_reg == '0) begin
            last_node = '0;
        end else if (node_count_reg > CNTCFG_W'(MAX_NODES)) begin
            last_node = NODE_W'(MAX_NODES - 1);
        end else begin
            last_node = NODE_W'(node_count_reg - CNTCFG_W'(1));
        end
    end

    gms_state_t state_reg, state_next;

    logic [NODE_W-1:0]  i_reg, j_reg;
    logic [LABEL_W-1:0] ci_reg;
    logic [DEG_W-1:0]   ki_reg;
    logic [TOT_W-1:0]   acc_reg, total_reg, s1_reg;
    logic [S2_W-1:0]    s2_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [Q1_W-1:0]    q1_reg;
    logic [W_W-1:0]     w_reg;
    logic [V_W-1:0]     v_reg;
    logic [TOT_W-1:0]   q2_reg;
    logic signed [31:0] mod_reg;
    logic               empty_reg;
    logic               m_valid_reg;

    logic               in_beat;
    logic               out_free;
    logic               last_j, last_i;

    gms_store_ctl_t     sctl;
    logic [WGT_W-1:0]   edge_rdata;
    logic [LABEL_W-1:0] comm_rdata;
    logic [DEG_W-1:0]   deg_rdata;
    gms_div_req_t       dreq;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;

    logic [NODE_W-1:0]  pmin, pmax;
    logic [V_W+RES_W-1:0] q2_full;
    logic signed [TOT_W+1:0] diff;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_j   = (j_reg == last_node);
    assign last_i   = (i_reg == last_node);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_beat && s_operation == OP_COMPUTE) state_next = ST_P1_ROW;
            ST_P1_ROW:    state_next = ST_P1_ROWW;
            ST_P1_ROWW:   state_next = ST_P1_RD;
            ST_P1_RD:     state_next = ST_P1_ACC;
            ST_P1_ACC:    state_next = last_j ? ST_P1_END : ST_P1_RD;
            ST_P1_END:    state_next = last_i ? ST_CHK : ST_P1_ROW;
            ST_CHK:       state_next = (total_reg == '0) ? ST_OUT : ST_P2_ROW;
            ST_P2_ROW:    state_next = ST_P2_ROWW;
            ST_P2_ROWW:   state_next = ST_P2_RD;
            ST_P2_RD:     state_next = ST_P2_ACC;
            ST_P2_ACC:    state_next = last_j ? ST_P2_MUL : ST_P2_RD;
            ST_P2_MUL:    state_next = ST_P2_ADD;
            ST_P2_ADD:    state_next = last_i ? ST_DIV1_GO : ST_P2_ROW;
            ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (div_done) state_next = ST_DIV2_GO;
            ST_DIV2_GO:   state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: if (div_done) state_next = ST_DIV3_GO;
            ST_DIV3_GO:   state_next = ST_DIV3_WAIT;
            ST_DIV3_WAIT: if (div_done) state_next = ST_MUL;
            ST_MUL:       state_next = ST_FIN;
            ST_FIN:       state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Memory and divider controls. Edge (i, j) lives at row min(i, j), column max(i, j).
    assign pmin = (i_reg < j_reg) ? i_reg : j_reg;
    assign pmax = (i_reg < j_reg) ? j_reg : i_reg;

    always_comb begin
        sctl            = '0;
        sctl.edge_waddr = {s_row_node, s_col_node};
        sctl.edge_wdata = s_edge_weight;
        sctl.comm_waddr = s_row_node;
        sctl.comm_wdata = s_community;
        sctl.deg_waddr  = i_reg;
        sctl.deg_wdata  = acc_reg[DEG_W-1:0];
        sctl.edge_raddr = {pmin, pmax};
        sctl.comm_raddr = j_reg;
        sctl.deg_raddr  = j_reg;
        dreq            = '0;
        dreq.divisor    = total_reg;
        case (state_reg)
            ST_IDLE: begin
                sctl.edge_we = in_beat && (s_operation == OP_LOAD_EDGE)
                               && (s_col_node >= s_row_node);
                sctl.comm_we = in_beat && (s_operation == OP_LOAD_COMM);
            end
            ST_P1_ROW, ST_P2_ROW: begin
                sctl.comm_raddr = i_reg;
                sctl.deg_raddr  = i_reg;
            end
            ST_P1_END: begin
                sctl.deg_we = 1'b1;
            end
            ST_DIV1_GO: begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_W'({s1_reg, 24'd0});
            end
            ST_DIV2_GO: begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_W'({s2_reg, 24'd0});
            end
            ST_DIV3_GO: begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_W'({w_reg, 12'd0});
            end
            default: ;
        endcase
    end

    assign q2_full = v_reg * resolution_reg;
    assign diff    = $signed({2'b00, TOT_W'(q1_reg)}) - $signed({2'b00, q2_reg});

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                i_reg     <= '0;
                total_reg <= '0;
                s1_reg    <= '0;
                s2_reg    <= '0;
            end
            ST_P1_ROWW, ST_P2_ROWW: begin
                ci_reg  <= comm_rdata;
                ki_reg  <= deg_rdata;
                j_reg   <= '0;
                acc_reg <= '0;
            end
            ST_P1_ACC: begin
                acc_reg <= acc_reg + TOT_W'(edge_rdata);
                if (comm_rdata == ci_reg) begin
                    s1_reg <= s1_reg + TOT_W'(edge_rdata);
                end
                if (!last_j) begin
                    j_reg <= j_reg + NODE_W'(1);
                end
            end
            ST_P1_END: begin
                total_reg <= total_reg + acc_reg;
                if (!last_i) begin
                    i_reg <= i_reg + NODE_W'(1);
                end
            end
            ST_CHK: begin
                i_reg <= '0;
            end
            ST_P2_ACC: begin
                if (comm_rdata == ci_reg) begin
                    acc_reg <= acc_reg + TOT_W'(deg_rdata);
                end
                if (!last_j) begin
                    j_reg <= j_reg + NODE_W'(1);
                end
            end
            ST_P2_MUL: begin
                prod_reg <= ki_reg * acc_reg;
            end
            ST_P2_ADD: begin
                s2_reg <= s2_reg + S2_W'(prod_reg);
                if (!last_i) begin
                    i_reg <= i_reg + NODE_W'(1);
                end
            end
            ST_DIV1_WAIT: if (div_done) q1_reg <= div_quot[Q1_W-1:0];
            ST_DIV2_WAIT: if (div_done) w_reg  <= div_quot[W_W-1:0];
            ST_DIV3_WAIT: if (div_done) v_reg  <= div_quot[V_W-1:0];
            ST_MUL: begin
                q2_reg <= q2_full[24 +: TOT_W];
            end
            ST_FIN: begin
                // The first term is at most 1.0 and the null-model term stays below 2^29,
                // so the difference always lies inside the 32-bit result range and the
                // saturation limits cannot be reached.
                mod_reg <= 32'(diff);
            end
            default: ;
        endcase
    end

    // Result register: loaded on leaving the sequencer, held until the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            empty_reg    <= (total_reg == '0);
            m_modularity <= (total_reg == '0) ? 32'sd0 : mod_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_empty_graph = empty_reg;

    gms_store u_store (
        .aclk       (aclk),
        .ctl        (sctl),
        .edge_rdata (edge_rdata),
        .comm_rdata (comm_rdata),
        .deg_rdata  (deg_rdata)
    );

    gms_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dreq),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

[rtl/gms_store.sv]
`timescale 1ns / 1ps
// Edge, community and degree memories with registered read ports.
module gms_store (
    input  logic                          aclk,
    input  gms_pkg::gms_store_ctl_t       ctl,
    output logic [gms_pkg::WGT_W-1:0]     edge_rdata,
    output logic [gms_pkg::LABEL_W-1:0]   comm_rdata,
    output logic [gms_pkg::DEG_W-1:0]     deg_rdata
);
    import gms_pkg::*;

    logic [WGT_W-1:0]   edge_mem [MAX_NODES*MAX_NODES];
    logic [LABEL_W-1:0] comm_mem [MAX_NODES];
    logic [DEG_W-1:0]   deg_mem  [MAX_NODES];

    always_ff @(posedge aclk) begin
        if (ctl.edge_we) begin
            edge_mem[ctl.edge_waddr] <= ctl.edge_wdata;
        end
        edge_rdata <= edge_mem[ctl.edge_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.comm_we) begin
            comm_mem[ctl.comm_waddr] <= ctl.comm_wdata;
        end
        comm_rdata <= comm_mem[ctl.comm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.deg_we) begin
            deg_mem[ctl.deg_waddr] <= ctl.deg_wdata;
        end
        deg_rdata <= deg_mem[ctl.deg_raddr];
    end

endmodule

[rtl/gms_divider.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by all three divisions.
module gms_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gms_pkg::gms_div_req_t        req,
    output logic                         done,
    output logic [gms_pkg::DIV_W-1:0]    quotient
);
    import gms_pkg::*;

    logic [DIV_W-1:0]  work_reg, work_next;
    logic [TOT_W-1:0]  rem_reg, rem_next;
    logic [TOT_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [TOT_W:0]    trial;
    logic              qbit;

    always_comb begin
        trial     = {rem_reg, work_reg[DIV_W-1]};
        qbit      = (trial >= {1'b0, dvs_reg});
        rem_next  = qbit ? TOT_W'(trial - {1'b0, dvs_reg}) : trial[TOT_W-1:0];
        work_next = {work_reg[DIV_W-2:0], qbit};
        cnt_next  = cnt_reg - DCNT_W'(1);
        done_next = (cnt_reg == DCNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            cnt_reg  <= DCNT_W'(DIV_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            work_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end else if (cnt_reg != '0) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

[rtl/gms_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the graph modularity score unit, with its bind.
module gms_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [1:0]                   s_operation,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [31:0]           m_modularity,
    input logic                         m_empty_graph
);
    import gms_pkg::*;

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_modularity) && $stable(m_empty_graph))
        else $error("stalled result beat changed");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_graph |-> m_modularity == 32'sd0)
        else $error("empty graph with nonzero modularity");

    a_busy_after_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_COMPUTE |=> !s_ready)
        else $error("ready right after a compute beat");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation != OP_COMPUTE && !m_valid |=> !m_valid)
        else $error("result appeared after a load beat");

endmodule

bind graph_modularity_score_unit gms_checker u_gms_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_operation   (s_operation),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_modularity  (m_modularity),
    .m_empty_graph (m_empty_graph)
);

[verif/tb_graph_modularity_score_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the graph modularity score unit.
module tb_graph_modularity_score_unit;
    import gms_pkg::*;

    // The watchdog allows several times the longest compute beat, with all 64
    // nodes in use, plus the receiver hold-off.
    localparam int WATCHDOG_LIMIT = 120000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic signed [31:0] modularity;
        logic               empty_graph;
    } score_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_operation;
    logic [NODE_W-1:0]    s_row_node;
    logic [NODE_W-1:0]    s_col_node;
    logic [WGT_W-1:0]     s_edge_weight;
    logic [LABEL_W-1:0]   s_community;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [31:0]   m_modularity;
    logic                 m_empty_graph;

    graph_modularity_score_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_row_node    (s_row_node),
        .s_col_node    (s_col_node),
        .s_edge_weight (s_edge_weight),
        .s_community   (s_community),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_modularity  (m_modularity),
        .m_empty_graph (m_empty_graph)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the block's state. The seen flags let the stimulus make
    // sure no compute ever reads an entry that was never loaded.
    logic [WGT_W-1:0]   weight_mem [0:MAX_NODES-1][0:MAX_NODES-1];
    bit                 weight_seen [0:MAX_NODES-1][0:MAX_NODES-1];
    logic [LABEL_W-1:0] label_mem [0:MAX_NODES-1];
    bit                 label_seen [0:MAX_NODES-1];
    logic [6:0]         node_count_reg;
    logic [15:0]        resolution_reg;

    score_t expected_scores[$];

    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_request;
    int holdoff_left;
    int mismatch_count;
    int beats_sent;
    int quiet_cycles;

    // floor(x * 2^s / d), split so that no intermediate overflows 64 bits.
    function automatic longint unsigned scaled_quotient(longint unsigned x,
                                                        longint unsigned d, int s);
        return ((x / d) << s) + (((x % d) << s) / d);
    endfunction

    // Modularity of the partition currently held in the shadow state.
    function automatic score_t modularity_of_partition();
        score_t          r;
        int              n;
        longint unsigned degree [0:MAX_NODES-1];
        longint unsigned label_sum [0:MAX_NODES-1];
        longint unsigned total, s1, s2, w, v, q1, q2;
        longint          q;
        n = node_count_reg;
        if (n == 0) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        total = 0; s1 = 0; s2 = 0;
        for (int i = 0; i < MAX_NODES; i++) begin
            degree[i] = 0;
            label_sum[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                degree[i] += weight_mem[i][j];
                if (j != i) degree[j] += weight_mem[i][j];
            end
        end
        for (int i = 0; i < n; i++) total += degree[i];
        if (total == 0) begin
            r.modularity = '0;
            r.empty_graph = 1'b1;
            return r;
        end
        for (int i = 0; i < n; i++) begin
            label_sum[label_mem[i]] += degree[i];
            for (int j = i; j < n; j++) begin
                if (label_mem[j] == label_mem[i])
                    s1 += (i == j) ? weight_mem[i][j] : 2 * weight_mem[i][j];
            end
        end
        for (int c = 0; c < MAX_NODES; c++) s2 += label_sum[c] * label_sum[c];
        w  = scaled_quotient(s2, total, 24);
        v  = scaled_quotient(w, total, 12);
        q2 = (longint'(resolution_reg) * v) >> 24;
        q1 = scaled_quotient(s1, total, 24);
        q  = longint'(q1) - longint'(q2);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        r.modularity = q[31:0];
        r.empty_graph = 1'b0;
        return r;
    endfunction

    // Applies one accepted input beat to the shadow state.
    function automatic void absorb_beat(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                        logic [15:0] wt, logic [5:0] com);
        case (op)
            OP_LOAD_EDGE: begin
                if (col >= row) begin
                    weight_mem[row][col] = wt;
                    weight_seen[row][col] = 1'b1;
                end
            end
            OP_LOAD_COMM: begin
                label_mem[row] = com;
                label_seen[row] = 1'b1;
            end
            OP_COMPUTE: expected_scores.push_back(modularity_of_partition());
            default: ;
        endcase
    endfunction

    // Offers one beat and returns at the edge where it is accepted. Valid is
    // left high so that a following beat can go out back to back; whoever
    // stops sending lowers it in that same time step.
    task automatic send_beat(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                             logic [15:0] wt, logic [5:0] com);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_row_node    <= row;
        s_col_node    <= col;
        s_edge_weight <= wt;
        s_community   <= com;
        do @(posedge aclk); while (!s_ready);
        absorb_beat(op, row, col, wt, com);
        beats_sent++;
    endtask

    // Stops the sender and waits until every expected score has come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_NODE_COUNT) node_count_reg = value[6:0];
        else resolution_reg = value;
    endtask

    function automatic logic [15:0] pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 16'h0000;
        if (r < 22) return 16'hFFFF;
        if (r < 30) return 16'(1 << $urandom_range(15));
        return 16'($urandom);
    endfunction

    function automatic int active_nodes();
        if (node_count_reg == 0) return 1;
        if (node_count_reg > MAX_NODES) return MAX_NODES;
        return node_count_reg;
    endfunction

    // Loads every entry a compute over the active nodes will read that has
    // not been loaded yet. Sparse graphs use mostly zero weights.
    task automatic fill_missing(bit sparse);
        int n;
        n = active_nodes();
        for (int i = 0; i < n; i++) begin
            if (!label_seen[i])
                send_beat(OP_LOAD_COMM, 6'(i), 6'($urandom), 16'($urandom),
                          6'($urandom_range(n < 4 ? 63 : 3)));
            for (int j = i; j < n; j++) begin
                if (!weight_seen[i][j])
                    send_beat(OP_LOAD_EDGE, 6'(i), 6'(j),
                              (sparse && $urandom_range(99) < 75) ? 16'h0 : pick_weight(),
                              6'($urandom));
            end
        end
    endtask

    task automatic compute_now();
        send_beat(OP_COMPUTE, 6'($urandom), 6'($urandom), 16'($urandom), 6'($urandom));
    endtask

    // Sender gaps and receiver stalls for one phase of the run.
    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // A graph whose weights are all zero gives the empty flag. A node count
    // of zero is treated as one node.
    task automatic test_empty_graph();
        write_reg(CFG_NODE_COUNT, 16'd0);
        send_beat(OP_LOAD_EDGE, 6'd0, 6'd0, 16'h0000, 6'd0);
        send_beat(OP_LOAD_COMM, 6'd0, 6'd0, 16'h0000, 6'd63);
        compute_now();
        send_beat(OP_LOAD_EDGE, 6'd0, 6'd0, 16'hFFFF, 6'd0);
        compute_now();
        write_reg(CFG_NODE_COUNT, 16'd2);
        send_beat(OP_LOAD_EDGE, 6'd0, 6'd1, 16'h0000, 6'd0);
        send_beat(OP_LOAD_EDGE, 6'd1, 6'd1, 16'h0000, 6'd0);
        send_beat(OP_LOAD_EDGE, 6'd0, 6'd0, 16'h0000, 6'd0);
        send_beat(OP_LOAD_COMM, 6'd1, 6'd0, 16'h0000, 6'd63);
        compute_now();
    endtask

    // Extreme weights and labels, edges below the diagonal, the unused
    // operation code, and the resolution at both ends of its range.
    task automatic test_directed_cases();
        write_reg(CFG_NODE_COUNT, 16'd3);
        send_beat(OP_LOAD_EDGE, 6'd0, 6'd1, 16'hFFFF, 6'd0);
        send_beat(OP_LOAD_EDGE, 6'd0, 6'd2, 16'h0001, 6'd0);
        send_beat(OP_LOAD_EDGE, 6'd1, 6'd2, 16'h8000, 6'd0);
        send_beat(OP_LOAD_EDGE, 6'd2, 6'd2, 16'hFFFF, 6'd0);
        send_beat(OP_LOAD_EDGE, 6'd1, 6'd0, 16'h1234, 6'd0);
        send_beat(OP_LOAD_EDGE, 6'd63, 6'd63, 16'hFFFF, 6'd63);
        send_beat(OP_LOAD_COMM, 6'd2, 6'd63, 16'hFFFF, 6'd63);
        send_beat(2'd3, 6'd63, 6'd0, 16'hFFFF, 6'd63);
        compute_now();
        write_reg(CFG_RESOLUTION, 16'd0);
        compute_now();
        write_reg(CFG_RESOLUTION, 16'hFFFF);
        send_beat(OP_LOAD_COMM, 6'd1, 6'd0, 16'h0, 6'd63);
        compute_now();
        compute_now();
    endtask

    // All 64 nodes in use: once through the clamped node count, once through
    // the exact maximum.
    task automatic test_full_graph();
        write_reg(CFG_NODE_COUNT, 16'd127);
        write_reg(CFG_RESOLUTION, 16'd4096);
        fill_missing(1'b1);
        compute_now();
        write_reg(CFG_NODE_COUNT, 16'd64);
        write_reg(CFG_RESOLUTION, 16'hFFFF);
        send_beat(OP_LOAD_EDGE, 6'd5, 6'd60, 16'hFFFF, 6'd0);
        compute_now();
    endtask

    // Rounds of loads with random content followed by a compute. Most loads
    // touch the active nodes; the rest are writes elsewhere, edges below the
    // diagonal and the unused code. Node counts stay small to keep it fast.
    task automatic test_random_rounds(int beat_budget);
        int stop_at, n, r, loads, a, b;
        stop_at = beats_sent + beat_budget;
        while (beats_sent < stop_at) begin
            if ($urandom_range(99) < 30) begin
                r = $urandom_range(99);
                write_reg(CFG_NODE_COUNT, 16'(r < 10 ? 1 : (r < 20 ? $urandom_range(9, 16)
                                                              : $urandom_range(2, 8))));
            end
            if ($urandom_range(99) < 20) begin
                r = $urandom_range(99);
                write_reg(CFG_RESOLUTION, 16'(r < 15 ? 0 : (r < 30 ? 16'hFFFF
                                                          : $urandom_range(8192))));
            end
            n = active_nodes();
            loads = $urandom_range(3, 30);
            repeat (loads) begin
                r = $urandom_range(99);
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
                if (r < 55)
                    send_beat(OP_LOAD_EDGE, 6'(a < b ? a : b), 6'(a < b ? b : a),
                              pick_weight(), 6'($urandom));
                else if (r < 80)
                    send_beat(OP_LOAD_COMM, 6'(a), 6'($urandom), 16'($urandom),
                              6'($urandom_range(99) < 50 ? $urandom_range(2)
                                                         : $urandom_range(63)));
                else if (r < 88) begin
                    a = $urandom_range(63);
                    b = $urandom_range(a, 63);
                    send_beat(OP_LOAD_EDGE, 6'(a), 6'(b), 16'($urandom), 6'($urandom));
                end else if (r < 92)
                    send_beat(OP_LOAD_COMM, 6'($urandom), 6'($urandom), 16'($urandom),
                              6'($urandom));
                else if (r < 96) begin
                    a = $urandom_range(1, 63);
                    send_beat(OP_LOAD_EDGE, 6'(a), 6'($urandom_range(a - 1)),
                              16'($urandom), 6'($urandom));
                end else
                    send_beat(2'd3, 6'($urandom), 6'($urandom), 16'($urandom),
                              6'($urandom));
            end
            fill_missing(1'b0);
            compute_now();
            if ($urandom_range(99) < 25) compute_now();
        end
    endtask

    // The receiver holds off for a long stretch while computes keep coming,
    // so the block holds a finished score and must stall its input.
    task automatic test_output_backpressure();
        write_reg(CFG_NODE_COUNT, 16'd3);
        fill_missing(1'b0);
        holdoff_request = 1500;
        repeat (5) begin
            send_beat(OP_LOAD_EDGE, 6'd0, 6'($urandom_range(2)), pick_weight(), 6'd0);
            compute_now();
        end
    endtask

    // Result side: random stalls, the hold-off, and the check of each beat.
    always @(posedge aclk) begin
        score_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_scores.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected score beat %0d empty %0b", $realtime,
                                 m_modularity, m_empty_graph);
                end else begin
                    want = expected_scores.pop_front();
                    if (m_modularity !== want.modularity ||
                        m_empty_graph !== want.empty_graph) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: score mismatch: expected %0d empty %0b, got %0d empty %0b",
                                     $realtime, want.modularity, want.empty_graph,
                                     m_modularity, m_empty_graph);
                    end
                end
            end
            if (holdoff_request > 0) begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data = '0;
        s_valid = 1'b0;
        s_operation = OP_LOAD_EDGE;
        s_row_node = '0;
        s_col_node = '0;
        s_edge_weight = '0;
        s_community = '0;
        m_ready = 1'b0;
        node_count_reg = 7'd64;
        resolution_reg = 16'd4096;
        mismatch_count = 0;
        beats_sent = 0;
        quiet_cycles = 0;
        holdoff_request = 0;
        holdoff_left = 0;
        for (int i = 0; i < MAX_NODES; i++) begin
            label_seen[i] = 1'b0;
            for (int j = 0; j < MAX_NODES; j++) weight_seen[i][j] = 1'b0;
        end
        set_idling(0, 0);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_graph();
        test_directed_cases();
        set_idling(0, 0);
        test_random_rounds(60);
        set_idling(46, 0);
        test_random_rounds(50);
        set_idling(0, 46);
        test_random_rounds(50);
        set_idling(22, 22);
        test_random_rounds(50);
        test_output_backpressure();
        set_idling(0, 0);
        test_full_graph();
        wait_idle();

        if (mismatch_count == 0 && expected_scores.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
